@@ sv/mcr_pkg.sv @@
package mcr_pkg;

	localparam int COORD_BITS = 12;
	localparam int OUT_BITS   = COORD_BITS + 1;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DEC_BITS   = COORD_BITS + 2;

	localparam int S_TDATA_BITS = ((2 * COORD_BITS + RAD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

	// eight symmetric points per step
	localparam int PTS_PER_STEP = 8;
	localparam int PT_CNT_BITS  = $clog2(PTS_PER_STEP);
	localparam logic [PT_CNT_BITS-1:0] PT_LAST = PT_CNT_BITS'(PTS_PER_STEP - 1);

	// request kinds carried in s_tuser
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// decision increments (integer form of the 5/4 - R midpoint test)
	localparam logic signed [DEC_BITS-1:0] DEC_INIT  = DEC_BITS'(1);
	localparam logic signed [DEC_BITS-1:0] DEC_DIAG  = DEC_BITS'(5);
	localparam logic signed [DEC_BITS-1:0] DEC_AXIS  = DEC_BITS'(3);

	// one step's worth of work handed to the point emitter
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] ox;
		logic signed [COORD_BITS-1:0] oy;
		logic                         done;
	} snap_t;

endpackage

@@ sv/mcr_emit.sv @@
module mcr_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              snap_load,
	input  mcr_pkg::snap_t                    snap_in,
	output logic                              snap_ready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mcr_pkg::M_TDATA_BITS-1:0]  m_tdata,  // point_x, point_y
	output logic                              m_tlast,  // step_last
	output logic                              m_tuser   // circle_done
);

	mcr_pkg::snap_t                         snap_s1;
	logic                                   snap_valid_s1;
	logic [mcr_pkg::PT_CNT_BITS-1:0]        cnt_q;

	logic                                   m_tvalid_q;
	logic signed [mcr_pkg::OUT_BITS-1:0]    px_q;
	logic signed [mcr_pkg::OUT_BITS-1:0]    py_q;
	logic                                   last_q;
	logic                                   done_q;

	logic                                   out_load;
	logic                                   last_pt;
	logic signed [mcr_pkg::OUT_BITS-1:0]    a_ext;
	logic signed [mcr_pkg::OUT_BITS-1:0]    b_ext;
	logic signed [mcr_pkg::OUT_BITS-1:0]    da;
	logic signed [mcr_pkg::OUT_BITS-1:0]    db;
	logic signed [mcr_pkg::OUT_BITS-1:0]    px_d;
	logic signed [mcr_pkg::OUT_BITS-1:0]    py_d;

	assign out_load   = snap_valid_s1 && (!m_tvalid_q || m_tready);
	assign last_pt    = cnt_q == mcr_pkg::PT_LAST;
	assign snap_ready = !snap_valid_s1 || (last_pt && out_load);

	// point order: (x,y) (x,-y) (-x,-y) (-x,y) (y,x) (y,-x) (-y,-x) (-y,x)
	always_comb begin
		a_ext = cnt_q[2] ? mcr_pkg::OUT_BITS'(snap_s1.oy) : mcr_pkg::OUT_BITS'(snap_s1.ox);
		b_ext = cnt_q[2] ? mcr_pkg::OUT_BITS'(snap_s1.ox) : mcr_pkg::OUT_BITS'(snap_s1.oy);
		da    = cnt_q[1] ? -a_ext : a_ext;
		db    = (cnt_q[1] ^ cnt_q[0]) ? -b_ext : b_ext;
		px_d  = mcr_pkg::OUT_BITS'(snap_s1.cx) + da;
		py_d  = mcr_pkg::OUT_BITS'(snap_s1.cy) + db;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
			cnt_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (snap_load) begin
				snap_valid_s1 <= 1'b1;
				cnt_q         <= '0;
			end else if (out_load) begin
				if (last_pt) begin
					snap_valid_s1 <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_s1 <= snap_in;
		end
		if (out_load) begin
			px_q   <= px_d;
			py_q   <= py_d;
			last_q <= last_pt;
			done_q <= last_pt && snap_s1.done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = mcr_pkg::M_TDATA_BITS'({py_q, px_q});
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

	// circle end is only ever flagged on the eighth point of a step
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("circle_done without step_last");

	// a new snapshot never overwrites one with points still pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |-> (!snap_valid_s1 || (last_pt && out_load)))
		else $error("snapshot overwritten");

endmodule

@@ sv/midpoint_circle_rasterizer_top.sv @@
// Midpoint circle rasterizer, eight-way symmetric.
// Input stream s_*: s_tuser selects the request. A start request (tuser 0)
// latches center and radius and produces nothing; it also aborts a circle
// in progress. A step request (tuser 1) while a circle is active yields
// eight points on m_*; a step while idle is consumed with no output.
// Output stream m_*: one point per transaction, tlast on the eighth point
// of a step, tuser on the last point of the circle.
// Timing: the circle state (offsets, decision) updates in the cycle a step
// is accepted; its points pass through the snapshot register and then the
// output register, one per cycle while m_tready allows. The point emitter
// holds one step at a time, so the next step is taken in the same cycle its
// predecessor's eighth point is loaded. Start requests are held back the
// same way since s_tready is shared.
// Stall: when m_tready is low the output register holds its point and the
// emitter waits; s_tready drops once a step is queued behind it.
// Reset (arst_n low): circle idle, no points pending, all offsets zero.
module midpoint_circle_rasterizer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mcr_pkg::S_TDATA_BITS-1:0]  s_tdata,  // center_x, center_y, radius
	input  logic                              s_tuser,  // req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mcr_pkg::M_TDATA_BITS-1:0]  m_tdata,  // point_x, point_y
	output logic                              m_tlast,  // step_last
	output logic                              m_tuser   // circle_done
);

	localparam int CB = mcr_pkg::COORD_BITS;
	localparam int DB = mcr_pkg::DEC_BITS;

	logic signed [CB-1:0]  ox_q;
	logic signed [CB-1:0]  oy_q;
	logic signed [DB-1:0]  dec_q;
	logic signed [CB-1:0]  cx_q;
	logic signed [CB-1:0]  cy_q;
	logic                  drawing_q;

	logic                          s_accept;
	logic                          is_start;
	logic                          snap_load;
	logic                          snap_ready;
	logic signed [CB-1:0]          in_cx;
	logic signed [CB-1:0]          in_cy;
	logic [mcr_pkg::RAD_BITS-1:0]  in_rad;
	logic signed [CB-1:0]          rad_ext;

	logic signed [DB-1:0]  xe;
	logic signed [DB-1:0]  ye;
	logic signed [DB-1:0]  dec_n;
	logic signed [CB-1:0]  ox_n;
	logic signed [CB-1:0]  oy_n;
	logic                  done_n;
	mcr_pkg::snap_t        snap;

	assign in_cx   = s_tdata[CB-1:0];
	assign in_cy   = s_tdata[2*CB-1:CB];
	assign in_rad  = s_tdata[2*CB+mcr_pkg::RAD_BITS-1:2*CB];
	assign rad_ext = CB'(in_rad);

	assign s_tready  = snap_ready;
	assign s_accept  = s_tvalid && s_tready;
	assign is_start  = s_tuser == mcr_pkg::REQ_START;
	assign snap_load = s_accept && !is_start && drawing_q;

	// midpoint update; decision >= 0 means the midpoint lies outside
	always_comb begin
		xe   = DB'(ox_q);
		ye   = DB'(oy_q);
		ox_n = ox_q + CB'(1);
		if (!dec_q[DB-1]) begin
			dec_n = dec_q + DB'((xe - ye) <<< 1) + mcr_pkg::DEC_DIAG;
			oy_n  = oy_q - CB'(1);
		end else begin
			dec_n = dec_q + DB'(xe <<< 1) + mcr_pkg::DEC_AXIS;
			oy_n  = oy_q;
		end
		done_n = ox_n > oy_n;
	end

	always_comb begin
		snap.cx   = cx_q;
		snap.cy   = cy_q;
		snap.ox   = ox_q;
		snap.oy   = oy_q;
		snap.done = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q      <= '0;
			oy_q      <= '0;
			dec_q     <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			drawing_q <= 1'b0;
		end else if (s_accept) begin
			if (is_start) begin
				cx_q      <= in_cx;
				cy_q      <= in_cy;
				ox_q      <= '0;
				oy_q      <= rad_ext;
				dec_q     <= mcr_pkg::DEC_INIT - DB'(rad_ext);
				drawing_q <= 1'b1;
			end else if (drawing_q) begin
				ox_q      <= ox_n;
				oy_q      <= oy_n;
				dec_q     <= dec_n;
				drawing_q <= !done_n;
			end
		end
	end

	mcr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_load  (snap_load),
		.snap_in    (snap),
		.snap_ready (snap_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// the circle only ends on an accepted step
	a_end_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drawing_q) |-> $past(snap_load))
		else $error("drawing ended without a step");

	// a start transaction always leaves the circle active with x at zero
	a_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && is_start |=> drawing_q && ox_q == '0)
		else $error("start did not arm circle");

endmodule

@@ tb/tb_midpoint_circle_rasterizer_top.sv @@
module tb_midpoint_circle_rasterizer_top;

	localparam int CYC_LIMIT  = 600000;
	localparam int HOLD_LEN   = 300;
	localparam int RAND_ITEMS = 448;
	localparam int OB         = mcr_pkg::OUT_BITS;

	typedef logic signed [mcr_pkg::COORD_BITS-1:0] coord_t;
	typedef logic [mcr_pkg::RAD_BITS-1:0]          rad_t;

	typedef struct packed {
		logic signed [OB-1:0] px;
		logic signed [OB-1:0] py;
		logic                 last;
		logic                 done;
	} point_t;

	typedef struct packed {
		logic                 req;
		coord_t               cx;
		coord_t               cy;
		rad_t                 r;
		logic                 typed;
		logic [3:0]           n_typ;
		logic signed [OB-1:0] tx;
		logic signed [OB-1:0] ty;
	} dir_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [mcr_pkg::S_TDATA_BITS-1:0]  s_tdata;
	logic                              s_tuser;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [mcr_pkg::M_TDATA_BITS-1:0]  m_tdata;
	logic                              m_tlast;
	logic                              m_tuser;

	midpoint_circle_rasterizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// circle tracker state
	coord_t                              circ_cx, circ_cy, circ_ox, circ_oy;
	logic signed [mcr_pkg::DEC_BITS-1:0] circ_dec;
	bit                                  circ_on;

	point_t pts_due[$];
	int     n_bad = 0;
	int     cyc = 0;
	bit     calm;
	bit     hold_req;

	// typed rows carry their points readable at a glance; the rest get expected points from the tracker
	dir_row_t dir_rows [22] = '{
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_START, 12'sd2047, 12'h800,   11'd0,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b1, 4'd8, 13'sd2047, 13'h1800},
		'{mcr_pkg::REQ_STEP,  12'hfff,   12'hfff,   11'h7ff,  1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_START, 12'h800,   12'sd2047, 11'd0,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b1, 4'd8, 13'h1800,  13'sd2047},
		'{mcr_pkg::REQ_START, 12'sd0,    12'sd0,    11'd1,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_START, 12'sd2047, 12'sd2047, 11'd2047, 1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'h555,   12'haaa,   11'h2aa,  1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_START, 12'h800,   12'h800,   11'd2047, 1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_START, 12'hfff,   12'hfff,   11'd5,    1'b1, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0},
		'{mcr_pkg::REQ_STEP,  12'sd0,    12'sd0,    11'd0,    1'b0, 4'd0, 13'sd0,    13'sd0}
	};

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int v;
		if (calm)
			return 0;
		v = $urandom_range(0, 99);
		if (v < 60)
			return 0;
		if (v < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// advance the circle tracker by one transaction; queue its points if keep is set
	function automatic void rasterize_req(input logic req, input coord_t cx, input coord_t cy,
			input rad_t r, input bit keep);
		int     x, y, a, b;
		point_t pt;
		if (req == mcr_pkg::REQ_START) begin
			circ_cx  = cx;
			circ_cy  = cy;
			circ_ox  = '0;
			circ_oy  = coord_t'(r);
			circ_dec = mcr_pkg::DEC_INIT - $signed({1'b0, r});
			circ_on  = 1'b1;
			return;
		end
		if (!circ_on)
			return;
		x = int'(circ_ox);
		y = int'(circ_oy);
		if (circ_dec >= 0) begin
			circ_dec = mcr_pkg::DEC_BITS'(circ_dec + 2 * (x - y) + mcr_pkg::DEC_DIAG);
			circ_oy  = coord_t'(y - 1);
		end else begin
			circ_dec = mcr_pkg::DEC_BITS'(circ_dec + 2 * x + mcr_pkg::DEC_AXIS);
		end
		circ_ox = coord_t'(x + 1);
		if (circ_ox > circ_oy)
			circ_on = 1'b0;
		// (x,y) (x,-y) (-x,-y) (-x,y), then the same signs on the swapped pair
		for (int k = 0; k < mcr_pkg::PTS_PER_STEP; k++) begin
			a = (k < 4) ? x : y;
			b = (k < 4) ? y : x;
			if ((k % 4) >= 2)
				a = -a;
			if ((k % 4) == 1 || (k % 4) == 2)
				b = -b;
			pt.px   = OB'(circ_cx + a);
			pt.py   = OB'(circ_cy + b);
			pt.last = (k == mcr_pkg::PTS_PER_STEP - 1);
			pt.done = (k == mcr_pkg::PTS_PER_STEP - 1) && !circ_on;
			if (keep)
				pts_due.push_back(pt);
		end
	endfunction

	// offer one request and wait for its transaction; counted is low for an ignored step
	task automatic send_req(input logic req, input coord_t cx, input coord_t cy, input rad_t r,
			input bit keep, output bit counted);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= mcr_pkg::S_TDATA_BITS'({r, cy, cx});
		do @(posedge clk); while (!s_tready);
		counted = (req == mcr_pkg::REQ_START) || circ_on;
		rasterize_req(req, cx, cy, r, keep);
	endtask

	// point receiver: checks transactions and paces m_tready
	int  hold_left = 0;
	int  rdy_wait = 0;
	bit  hold_seen = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pts_due.size() == 0) begin
					$display("%0t unexpected point: expected none, got x %0d y %0d last %0b done %0b",
						$time, $signed(m_tdata[OB-1:0]), $signed(m_tdata[2*OB-1:OB]),
						m_tlast, m_tuser);
					n_bad++;
				end else begin
					point_t want;
					want = pts_due.pop_front();
					if (m_tdata[OB-1:0] !== want.px) begin
						$display("%0t point_x expected %0d got %0d", $time, want.px,
							$signed(m_tdata[OB-1:0]));
						n_bad++;
					end
					if (m_tdata[2*OB-1:OB] !== want.py) begin
						$display("%0t point_y expected %0d got %0d", $time, want.py,
							$signed(m_tdata[2*OB-1:OB]));
						n_bad++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t step_last expected %0b got %0b", $time, want.last, m_tlast);
						n_bad++;
					end
					if (m_tuser !== want.done) begin
						$display("%0t circle_done expected %0b got %0b", $time, want.done, m_tuser);
						n_bad++;
					end
				end
			end
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rdy_wait > 0) begin
				rdy_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rdy_wait = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("midpoint_circle_rasterizer_top test failed");
			$finish;
		end
	end

	initial begin
		int       n_sent;
		int       steps_cap;
		bit       counted;
		bit       drained;
		rad_t     r;
		dir_row_t row;

		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = mcr_pkg::REQ_START;
		calm      = 1'b0;
		hold_req  = 1'b0;
		circ_cx   = '0;
		circ_cy   = '0;
		circ_ox   = '0;
		circ_oy   = '0;
		circ_dec  = '0;
		circ_on   = 1'b0;
		n_sent    = 0;
		drained   = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.typed)
				for (int k = 0; k < row.n_typ; k++)
					pts_due.push_back('{row.tx, row.ty, k == mcr_pkg::PTS_PER_STEP - 1,
						k == mcr_pkg::PTS_PER_STEP - 1});
			send_req(row.req, row.cx, row.cy, row.r, !row.typed, counted);
		end

		while (n_sent < RAND_ITEMS) begin
			calm = ($urandom_range(0, 6) == 0);
			// long receiver hold-off while steps keep coming
			if (n_sent > 150)
				hold_req = 1'b1;
			// let everything drain once before carrying on
			if (n_sent > 300 && !drained) begin
				drained = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pts_due.size() > 0);
			end
			if ($urandom_range(0, 99) < 80) begin
				r = ($urandom_range(0, 99) < 85) ? rad_t'($urandom_range(0, 40)) :
					rad_t'($urandom_range(0, 2047));
				send_req(mcr_pkg::REQ_START, coord_t'($urandom), coord_t'($urandom), r, 1'b1,
					counted);
				n_sent++;
				// big circles and some small ones get cut short by the next start
				steps_cap = (r > 40 || $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 4096;
				for (int k = 0; k < steps_cap && circ_on; k++) begin
					send_req(mcr_pkg::REQ_STEP, coord_t'($urandom), coord_t'($urandom),
						rad_t'($urandom), 1'b1, counted);
					n_sent++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_req(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
						rad_t'($urandom), 1'b1, counted);
					if (counted)
						n_sent++;
				end
			end
		end

		calm = 1'b0;
		s_tvalid <= 1'b0;
		while (pts_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_bad == 0)
			$display("midpoint_circle_rasterizer_top test passed");
		else
			$display("midpoint_circle_rasterizer_top test failed");
		$finish;
	end

endmodule
